[rtl/core/clns_pkg.sv]
// ----------------------------------------------------------------------------
// clns_pkg
// Shared codes, payload types and byte helpers for the character-LCD
// nibble sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

    localparam int IDX_W = 4;

    localparam logic [3:0] MODE_INIT    = 4'd0;
    localparam logic [3:0] MODE_DATA    = 4'd1;
    localparam logic [3:0] MODE_GOTO    = 4'd2;
    localparam logic [3:0] MODE_CLEAR   = 4'd3;
    localparam logic [3:0] MODE_SETMODE = 4'd4;
    localparam logic [3:0] MODE_DISPLAY = 4'd5;
    localparam logic [3:0] MODE_CURSOR  = 4'd6;
    localparam logic [3:0] MODE_BLINK   = 4'd7;
    localparam logic [3:0] MODE_POWER   = 4'd8;

    localparam logic [1:0] KIND_NIBBLE  = 2'd0;
    localparam logic [1:0] KIND_DELAY   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [2:0] WAIT_NONE  = 3'd0;
    localparam logic [2:0] WAIT_READY = 3'd1;
    localparam logic [2:0] WAIT_5MS   = 3'd2;
    localparam logic [2:0] WAIT_150US = 3'd3;
    localparam logic [2:0] WAIT_50US  = 3'd4;
    localparam logic [2:0] WAIT_17MS  = 3'd5;

    localparam logic CFG_TWO_LINE  = 1'b0;
    localparam logic CFG_FONT_TALL = 1'b1;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_ENTRY = 8'h06;
    localparam logic [7:0] CMD_FUNC  = 8'h20;
    localparam logic [7:0] CMD_DISP  = 8'h08;
    localparam logic [3:0] NIB_WAKE  = 4'b0011;
    localparam logic [3:0] NIB_4BIT  = 4'b0010;

    localparam logic [IDX_W-1:0] IDX_BYTE_LAST  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_OFF_LAST   = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_INIT_BYTES = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_INIT_LAST  = IDX_W'(12);

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] value;
        logic [5:0] column;
        logic [1:0] row;
        logic       display_bit;
        logic       cursor_bit;
        logic       blink_bit;
        logic       enable;
    } t_req;

    typedef struct packed {
        logic display;
        logic cursor;
        logic blink;
    } t_flags;

    typedef struct packed {
        logic two_line;
        logic font_tall;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic       reg_select;
        logic [3:0] nibble;
        logic [2:0] wait_code;
        logic       last;
    } t_res;

    function automatic logic [7:0] mode_byte(input logic d, input logic c, input logic b);
        mode_byte = CMD_DISP | {5'b00000, d, c, b};
    endfunction

    function automatic logic [7:0] row_base(input logic [1:0] row);
        case (row)
            2'd0:    row_base = 8'h80;
            2'd1:    row_base = 8'h80 + 8'h40;
            2'd2:    row_base = 8'h80 + 8'h14;
            default: row_base = 8'h80 + 8'h54;
        endcase
    endfunction

    function automatic logic mode_known(input logic [3:0] mode);
        mode_known = (mode <= MODE_POWER);
    endfunction

endpackage

[rtl/core/clns_if.sv]
// ----------------------------------------------------------------------------
// clns_if
// Handshake channels of the sequencer: request, result and register write.
// ----------------------------------------------------------------------------
interface clns_req_if
    import clns_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [3:0] mode;
    logic [7:0] value;
    logic [5:0] column;
    logic [1:0] row;
    logic       display_bit;
    logic       cursor_bit;
    logic       blink_bit;
    logic       enable;

    modport source (output valid, mode, value, column, row, display_bit, cursor_bit,
                    blink_bit, enable, input ready);
    modport sink   (input valid, mode, value, column, row, display_bit, cursor_bit,
                    blink_bit, enable, output ready);
endinterface

interface clns_res_if
    import clns_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       reg_select;
    logic [3:0] nibble;
    logic [2:0] wait_code;
    logic       last;

    modport source (output valid, kind, reg_select, nibble, wait_code, last, input ready);
    modport sink   (input valid, kind, reg_select, nibble, wait_code, last, output ready);
endinterface

interface clns_cfg_if
    import clns_pkg::*;
;
    logic valid;
    logic ready;
    logic index;
    logic data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/clns_step_gen.sv]
// ----------------------------------------------------------------------------
// clns_step_gen
// Result decoder: maps the held request and the result index to one
// nibble, delay or release beat.
// ----------------------------------------------------------------------------
module clns_step_gen
    import clns_pkg::*;
(
    input  t_req             i_req,
    input  logic [IDX_W-1:0] i_idx,
    input  t_flags           i_flags,
    input  t_cfg             i_cfg,
    output t_res             o_res
);

    logic [7:0]       byte_val;
    logic             byte_rs;
    logic             byte_lo;
    logic [IDX_W-1:0] init_pos;
    logic             power_off;

    assign power_off = (i_req.mode == MODE_POWER) && !i_req.enable;
    assign init_pos  = i_idx - IDX_INIT_BYTES;

    always_comb begin
        byte_val = CMD_DISP;
        byte_rs  = 1'b0;
        byte_lo  = i_idx[0];
        case (i_req.mode)
            MODE_INIT: begin
                byte_lo = init_pos[0];
                case (init_pos[2:1])
                    2'd0:    byte_val = CMD_FUNC | {4'b0000, i_cfg.two_line,
                                                    i_cfg.font_tall, 2'b00};
                    2'd1:    byte_val = CMD_ENTRY;
                    2'd2:    byte_val = CMD_CLEAR;
                    default: byte_val = mode_byte(1'b1, 1'b0, 1'b0);
                endcase
            end
            MODE_DATA: begin
                byte_val = i_req.value;
                byte_rs  = 1'b1;
            end
            MODE_GOTO:    byte_val = row_base(i_req.row) + {2'b00, i_req.column};
            MODE_CLEAR:   byte_val = CMD_CLEAR;
            MODE_SETMODE: byte_val = mode_byte(i_req.display_bit, i_req.cursor_bit,
                                               i_req.blink_bit);
            default: begin
                if (power_off) begin
                    byte_val = CMD_DISP;
                end else begin
                    byte_val = mode_byte(i_flags.display, i_flags.cursor, i_flags.blink);
                end
            end
        endcase
    end

    always_comb begin
        o_res.kind       = KIND_NIBBLE;
        o_res.reg_select = byte_rs;
        o_res.nibble     = byte_lo ? byte_val[3:0] : byte_val[7:4];
        o_res.wait_code  = byte_lo ? WAIT_READY : WAIT_NONE;
        o_res.last       = (i_idx == IDX_BYTE_LAST);
        if (i_req.mode == MODE_INIT) begin
            o_res.last = (i_idx == IDX_INIT_LAST);
            case (i_idx)
                IDX_W'(0): begin
                    o_res.kind      = KIND_DELAY;
                    o_res.nibble    = 4'd0;
                    o_res.wait_code = WAIT_17MS;
                end
                IDX_W'(1): begin
                    o_res.nibble    = NIB_WAKE;
                    o_res.wait_code = WAIT_5MS;
                end
                IDX_W'(2): begin
                    o_res.nibble    = NIB_WAKE;
                    o_res.wait_code = WAIT_150US;
                end
                IDX_W'(3): begin
                    o_res.nibble    = NIB_WAKE;
                    o_res.wait_code = WAIT_50US;
                end
                IDX_W'(4): begin
                    o_res.nibble    = NIB_4BIT;
                    o_res.wait_code = WAIT_READY;
                end
                default: ;
            endcase
        end else if (power_off) begin
            o_res.last = (i_idx == IDX_OFF_LAST);
            if (i_idx == IDX_OFF_LAST) begin
                o_res.kind       = KIND_RELEASE;
                o_res.reg_select = 1'b0;
                o_res.nibble     = 4'd0;
                o_res.wait_code  = WAIT_NONE;
            end
        end
    end

endmodule

[rtl/core/char_lcd_nibble_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// 4-bit character-LCD write sequencer with display flags and init options.
// ----------------------------------------------------------------------------
// One result beat leaves per cycle from a registered output stage while the
// result side is ready. A request gives 2 result beats for data, goto,
// clear, set mode, flag and power-on requests, 3 for power-off, 13 for
// init, and none for an undefined mode. The next request is taken in the
// cycle its predecessor's last beat is loaded, so requests follow each
// other with no gap. The result counter over the held request sets these
// figures.
module char_lcd_nibble_sequencer
    import clns_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    clns_req_if.sink    i_req,
    clns_res_if.source  o_res,
    clns_cfg_if.sink    i_cfg
);

    logic             r_busy, n_busy;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_req             r_req;
    t_flags           r_flags, n_flags;
    t_cfg             r_cfg, n_cfg;
    logic             r_out_valid, n_out_valid;
    t_res             r_out;
    t_res             gen_res;
    t_req             in_req;
    logic             out_free, step, req_fire;

    assign in_req = '{mode: i_req.mode, value: i_req.value, column: i_req.column,
                      row: i_req.row, display_bit: i_req.display_bit,
                      cursor_bit: i_req.cursor_bit, blink_bit: i_req.blink_bit,
                      enable: i_req.enable};

    clns_step_gen u_step_gen (
        .i_req   (r_req),
        .i_idx   (r_idx),
        .i_flags (r_flags),
        .i_cfg   (r_cfg),
        .o_res   (gen_res)
    );

    assign out_free    = !r_out_valid || o_res.ready;
    assign step        = r_busy && out_free;
    assign i_req.ready = !r_busy || (step && gen_res.last);
    assign req_fire    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_flags     = r_flags;
        n_cfg       = r_cfg;
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (step) begin
            if (gen_res.last) begin
                n_busy = 1'b0;
                n_idx  = '0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
        if (req_fire) begin
            n_busy = mode_known(i_req.mode);
            n_idx  = '0;
            if (i_req.mode == MODE_DISPLAY ||
                (i_req.mode == MODE_POWER && i_req.enable)) begin
                n_flags.display = i_req.enable;
            end
            if (i_req.mode == MODE_CURSOR) begin
                n_flags.cursor = i_req.enable;
            end
            if (i_req.mode == MODE_BLINK) begin
                n_flags.blink = i_req.enable;
            end
        end
        if (i_cfg.valid) begin
            if (i_cfg.index == CFG_TWO_LINE) begin
                n_cfg.two_line = i_cfg.data;
            end else begin
                n_cfg.font_tall = i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_flags     <= '0;
            r_cfg       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_flags     <= n_flags;
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req <= in_req;
        end
        if (step) begin
            r_out <= gen_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out.kind;
    assign o_res.reg_select = r_out.reg_select;
    assign o_res.nibble     = r_out.nibble;
    assign o_res.wait_code  = r_out.wait_code;
    assign o_res.last       = r_out.last;

    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !out_free |=> $stable(r_idx))
        else $error("result index moved while output stalled");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> r_busy)
        else $error("request blocked while sequencer idle");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= IDX_INIT_LAST))
        else $error("result index out of range");

    a_short_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_req.mode != MODE_INIT |-> (r_idx <= IDX_OFF_LAST))
        else $error("non-init request ran past three beats");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("result beat lost at output stage");

endmodule

[verif/tb_char_lcd_nibble_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer
// Self-checking bench for the character-LCD nibble sequencer. A directed
// pass covers every request, the goto wrap, undefined modes and the
// power-off release. Random requests then follow under all init settings.
// Both sides of the block draw random idle gaps, and one long result stall
// lets the block back up. A scoreboard predicts every result beat in order.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer;
    import clns_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 16;
    localparam int PHASE_ITEMS  = 75;
    localparam int REPORT_LIMIT = 10;

    class lcd_scoreboard;
        t_res   expected_beats[$];
        t_cfg   regs;
        t_flags flags;
        int     mismatches;

        function new();
            regs.two_line  = 1'b1;
            regs.font_tall = 1'b1;
            flags          = '0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic idx, logic data);
            if (idx == CFG_TWO_LINE) begin
                regs.two_line = data;
            end else begin
                regs.font_tall = data;
            end
        endfunction

        function void push_beat(logic [1:0] kind, logic rs, logic [3:0] nib,
                                logic [2:0] wcode);
            t_res b;
            b.kind       = kind;
            b.reg_select = rs;
            b.nibble     = nib;
            b.wait_code  = wcode;
            b.last       = 1'b0;
            expected_beats.push_back(b);
        endfunction

        function void push_byte(logic [7:0] b, logic rs);
            push_beat(KIND_NIBBLE, rs, b[7:4], WAIT_NONE);
            push_beat(KIND_NIBBLE, rs, b[3:0], WAIT_READY);
        endfunction

        function logic [7:0] display_ctrl(logic d, logic c, logic b);
            return CMD_DISP | {5'b00000, d, c, b};
        endfunction

        function logic [7:0] ddram_address(logic [1:0] row, logic [5:0] column);
            logic [7:0] start;
            case (row)
                2'd0:    start = 8'h80;
                2'd1:    start = 8'hC0;
                2'd2:    start = 8'h94;
                default: start = 8'hD4;
            endcase
            return start + {2'b00, column};
        endfunction

        function void note_request(t_req r);
            int count_prior;
            count_prior = expected_beats.size();
            case (r.mode)
                MODE_INIT: begin
                    push_beat(KIND_DELAY, 1'b0, 4'h0, WAIT_17MS);
                    push_beat(KIND_NIBBLE, 1'b0, NIB_WAKE, WAIT_5MS);
                    push_beat(KIND_NIBBLE, 1'b0, NIB_WAKE, WAIT_150US);
                    push_beat(KIND_NIBBLE, 1'b0, NIB_WAKE, WAIT_50US);
                    push_beat(KIND_NIBBLE, 1'b0, NIB_4BIT, WAIT_READY);
                    push_byte(CMD_FUNC | {4'b0000, regs.two_line, regs.font_tall, 2'b00},
                              1'b0);
                    push_byte(CMD_ENTRY, 1'b0);
                    push_byte(CMD_CLEAR, 1'b0);
                    push_byte(display_ctrl(1'b1, 1'b0, 1'b0), 1'b0);
                end
                MODE_DATA:    push_byte(r.value, 1'b1);
                MODE_GOTO:    push_byte(ddram_address(r.row, r.column), 1'b0);
                MODE_CLEAR:   push_byte(CMD_CLEAR, 1'b0);
                MODE_SETMODE: push_byte(display_ctrl(r.display_bit, r.cursor_bit,
                                                     r.blink_bit), 1'b0);
                MODE_DISPLAY, MODE_CURSOR, MODE_BLINK, MODE_POWER: begin
                    if (r.mode == MODE_POWER && !r.enable) begin
                        push_byte(display_ctrl(1'b0, 1'b0, 1'b0), 1'b0);
                        push_beat(KIND_RELEASE, 1'b0, 4'h0, WAIT_NONE);
                    end else begin
                        if (r.mode == MODE_CURSOR) begin
                            flags.cursor = r.enable;
                        end else if (r.mode == MODE_BLINK) begin
                            flags.blink = r.enable;
                        end else begin
                            flags.display = r.enable;
                        end
                        push_byte(display_ctrl(flags.display, flags.cursor, flags.blink),
                                  1'b0);
                    end
                end
                default: ;
            endcase
            if (expected_beats.size() > count_prior) begin
                expected_beats[expected_beats.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR %0t: unexpected beat kind=%0d rs=%0d nib=%h wait=%0d last=%0d",
                             $realtime, got.kind, got.reg_select, got.nibble,
                             got.wait_code, got.last);
                end
                return;
            end
            want = expected_beats.pop_front();
            if (got.kind !== want.kind || got.reg_select !== want.reg_select ||
                got.nibble !== want.nibble || got.wait_code !== want.wait_code ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR %0t: expected kind=%0d rs=%0d nib=%h wait=%0d last=%0d",
                             $realtime, want.kind, want.reg_select, want.nibble,
                             want.wait_code, want.last);
                    $display("      %0t:      got kind=%0d rs=%0d nib=%h wait=%0d last=%0d",
                             $realtime, got.kind, got.reg_select, got.nibble,
                             got.wait_code, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    bit   hold_results;

    clns_req_if req_if ();
    clns_res_if res_if ();
    clns_cfg_if cfg_if ();

    lcd_scoreboard sb = new();

    char_lcd_nibble_sequencer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int pick_gap();
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   sel;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            r.mode = MODE_INIT;
        end else if (sel < 10) begin
            r.mode = 4'($urandom_range(int'(MODE_POWER) + 1, 15));
        end else begin
            r.mode = 4'($urandom_range(int'(MODE_DATA), int'(MODE_POWER)));
        end
        r.value       = 8'($urandom_range(0, 255));
        r.column      = 6'($urandom_range(0, 63));
        r.row         = 2'($urandom_range(0, 3));
        r.display_bit = 1'($urandom_range(0, 1));
        r.cursor_bit  = 1'($urandom_range(0, 1));
        r.blink_bit   = 1'($urandom_range(0, 1));
        r.enable      = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic send_request(t_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.mode        <= r.mode;
        req_if.value       <= r.value;
        req_if.column      <= r.column;
        req_if.row         <= r.row;
        req_if.display_bit <= r.display_bit;
        req_if.cursor_bit  <= r.cursor_bit;
        req_if.blink_bit   <= r.blink_bit;
        req_if.enable      <= r.enable;
        req_if.valid       <= 1'b1;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_request(r);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_registers(logic two, logic tall);
        cfg_if.index <= CFG_TWO_LINE;
        cfg_if.data  <= two;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        sb.write_reg(CFG_TWO_LINE, two);
        cfg_if.index <= CFG_FONT_TALL;
        cfg_if.data  <= tall;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        sb.write_reg(CFG_FONT_TALL, tall);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : result_sink
        int   stall;
        t_res got;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.kind       = res_if.kind;
            got.reg_select = res_if.reg_select;
            got.nibble     = res_if.nibble;
            got.wait_code  = res_if.wait_code;
            got.last       = res_if.last;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        t_req r;
        int   n;
        logic two_sel  [4] = '{1'b0, 1'b0, 1'b1, 1'b1};
        logic tall_sel [4] = '{1'b0, 1'b1, 1'b0, 1'b1};

        calm         = 1'b0;
        hold_results = 1'b0;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.mode        <= MODE_INIT;
        req_if.value       <= '0;
        req_if.column      <= '0;
        req_if.row         <= '0;
        req_if.display_bit <= 1'b0;
        req_if.cursor_bit  <= 1'b0;
        req_if.blink_bit   <= 1'b0;
        req_if.enable      <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= CFG_TWO_LINE;
        cfg_if.data        <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_registers(1'b1, 1'b1);

        send_request('{MODE_INIT,    8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b0});
        send_request('{MODE_DATA,    8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b0});
        send_request('{MODE_DATA,    8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1});
        send_request('{MODE_DATA,    8'hA5, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b0});
        send_request('{MODE_GOTO,    8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b0});
        send_request('{MODE_GOTO,    8'h00, 6'd39, 2'd1, 1'b0, 1'b0, 1'b0, 1'b0});
        send_request('{MODE_GOTO,    8'h00, 6'd63, 2'd2, 1'b0, 1'b0, 1'b0, 1'b0});
        send_request('{MODE_GOTO,    8'h00, 6'd44, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0});
        send_request('{MODE_GOTO,    8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1});
        send_request('{MODE_CLEAR,   8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b0});
        send_request('{MODE_SETMODE, 8'h00, 6'd0,  2'd0, 1'b1, 1'b1, 1'b1, 1'b0});
        send_request('{MODE_SETMODE, 8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        send_request('{MODE_SETMODE, 8'h00, 6'd0,  2'd0, 1'b1, 1'b0, 1'b1, 1'b0});
        send_request('{MODE_DISPLAY, 8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        send_request('{MODE_CURSOR,  8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        send_request('{MODE_BLINK,   8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        send_request('{MODE_CURSOR,  8'h00, 6'd0,  2'd0, 1'b1, 1'b1, 1'b1, 1'b0});
        send_request('{MODE_DISPLAY, 8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b0});
        send_request('{MODE_POWER,   8'h00, 6'd0,  2'd0, 1'b1, 1'b1, 1'b1, 1'b0});
        send_request('{MODE_POWER,   8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        send_request('{4'd9,         8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1});
        send_request('{4'd15,        8'h5A, 6'd21, 2'd2, 1'b0, 1'b1, 1'b0, 1'b1});
        send_request('{MODE_BLINK,   8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0, 1'b0});
        send_request('{MODE_INIT,    8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1});

        for (int p = 0; p < 4; p++) begin
            drain();
            set_registers(two_sel[p], tall_sel[p]);
            r = random_request();
            r.mode = MODE_INIT;
            send_request(r);
            if (p == 1) begin
                hold_results = 1'b1;
            end
            n = 0;
            while (n < PHASE_ITEMS) begin
                calm = (p == 1 && n < 40) || (n % 40 >= 30);
                r = random_request();
                send_request(r);
                if (r.mode <= MODE_POWER) begin
                    n++;
                end
            end
            calm = 1'b0;
        end

        drain();
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
